// ===== rtl/text_mode_console_writer_top_macros.svh =====
// Assertion helpers shared by the console writer modules.
`ifndef TEXT_MODE_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TMCW_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TMCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tmcw_pkg.sv =====
package tmcw_pkg;

    // Screen geometry
    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TAB_WIDTH   = 8;
    localparam int CELLS       = COLUMNS * ROWS;
    // The bottom row is never written, so only the rows above it are stored
    localparam int USED_CELLS  = COLUMNS * (ROWS - 1);
    // Cells that take a copy from the row below during a scroll
    localparam int SHIFT_CELLS = COLUMNS * (ROWS - 2);

    // Field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;

    // Internal widths
    localparam int ADDR_W = $clog2(USED_CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COLT_W = $clog2(COLUMNS + TAB_WIDTH);
    localparam int LIN_W  = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    // Opcodes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] KEY_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] KEY_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] KEY_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] KEY_CR  = 8'h0D;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // Next tab stop for each column, built at elaboration
    typedef logic [COLUMNS-1:0][COLT_W-1:0] t_tab_tbl;

    function automatic t_tab_tbl build_tab_tbl();
        t_tab_tbl tbl;
        for (int i = 0; i < COLUMNS; i++) begin
            tbl[i] = COLT_W'(i - (i % TAB_WIDTH) + TAB_WIDTH);
        end
        return tbl;
    endfunction

    localparam t_tab_tbl TAB_TBL = build_tab_tbl();

    // Controller states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_CLEAR,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic put_exec;
        logic home;
        logic sweep_clr;
        logic scroll_step;
        logic clear_step;
        logic rd_cell;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            put_scroll;
        logic            sweep_last;
    } t_dp_sts;

endpackage

// ===== rtl/tmcw_ctrl.sv =====
`include "text_mode_console_writer_top_macros.svh"

module tmcw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tmcw_pkg::t_dp_cmd o_cmd,
    input  tmcw_pkg::t_dp_sts i_sts
);
    import tmcw_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                // zero the store once after reset
                o_cmd.clear_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_sts.op)
                    OP_PUT: begin
                        o_cmd.put_exec = 1'b1;
                        if (i_sts.put_scroll) begin
                            o_cmd.sweep_clr = 1'b1;
                            n_state         = S_SCROLL;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.home      = 1'b1;
                        o_cmd.sweep_clr = 1'b1;
                        n_state         = S_CLEAR;
                    end
                    OP_READ: begin
                        o_cmd.rd_cell = 1'b1;
                        n_state       = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `TMCW_ASSERT_IMPLY(a_out_no_overrun, i_clk, i_rst_n, o_cmd.out_load,
        !r_out_valid || i_out_ready, "result register overwritten before transaction")
    `TMCW_ASSERT_NEXT(a_scroll_runs_out, i_clk, i_rst_n,
        (r_state == S_SCROLL) && !i_sts.sweep_last, r_state == S_SCROLL,
        "scroll sweep left early")
    `TMCW_ASSERT_IMPLY(a_ready_only_idle, i_clk, i_rst_n, o_in_ready,
        r_state == S_IDLE, "input ready outside idle")

endmodule

// ===== rtl/tmcw_dp.sv =====
`include "text_mode_console_writer_top_macros.svh"

module tmcw_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tmcw_pkg::t_dp_cmd               i_cmd,
    output tmcw_pkg::t_dp_sts               o_sts,
    input  logic [tmcw_pkg::OP_W-1:0]       i_opcode,
    input  logic [tmcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tmcw_pkg::IDX_W-1:0]      i_cell_index,
    input  logic                            i_cfg_valid,
    input  logic [tmcw_pkg::ATTR_W-1:0]     i_cfg_data,
    output logic [tmcw_pkg::POS_W-1:0]      o_cursor_pos,
    output logic [tmcw_pkg::CHAR_W-1:0]     o_cell_char,
    output logic [tmcw_pkg::ATTR_W-1:0]     o_cell_attr,
    output logic                            o_scrolled
);
    import tmcw_pkg::*;

    // Screen store, character and attribute planes
    logic [CHAR_W-1:0] mem_char [USED_CELLS];
    logic [ATTR_W-1:0] mem_attr [USED_CELLS];

    logic [ATTR_W-1:0] r_attr;
    logic [OP_W-1:0]   r_op;
    logic [CHAR_W-1:0] r_char;
    logic [IDX_W-1:0]  r_idx;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic              r_scr;
    logic [ADDR_W-1:0] r_cnt;
    logic              r_wpend;
    logic              r_wzero;
    logic [ADDR_W-1:0] r_waddr;
    logic [CHAR_W-1:0] r_rd_char;
    logic [ATTR_W-1:0] r_rd_attr;
    logic [POS_W-1:0]  r_out_pos;
    logic [CHAR_W-1:0] r_out_char;
    logic [ATTR_W-1:0] r_out_attr;
    logic              r_out_scr;

    logic [ADDR_W-1:0] lin;
    logic [LIN_W-1:0]  lin_w;
    logic              idx_ok;
    logic              cnt_in_shift;
    logic [COLT_W-1:0] col_t;
    logic [ROW_W-1:0]  row_t;
    logic [ROW_W-1:0]  put_row;
    logic              put_scroll;
    logic              put_we_char;
    logic              put_we_attr;
    logic [ADDR_W-1:0] put_addr;
    logic [CHAR_W-1:0] put_wchar;
    logic              w_en_c;
    logic              w_en_a;
    logic [ADDR_W-1:0] w_addr;
    logic [CHAR_W-1:0] w_char;
    logic [ATTR_W-1:0] w_attr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Linear cursor address and read range check
    assign lin          = ADDR_W'(r_row * COLUMNS) + ADDR_W'(r_col);
    assign lin_w        = LIN_W'(lin);
    assign idx_ok       = LIN_W'(r_idx) < LIN_W'(USED_CELLS);
    assign cnt_in_shift = r_cnt < ADDR_W'(SHIFT_CELLS);

    // Attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    // Command latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_opcode;
            r_char <= i_char_code;
            r_idx  <= i_cell_index;
        end
    end

    // Put-character cursor move and cell write
    always_comb begin
        col_t       = COLT_W'(r_col);
        row_t       = r_row;
        put_we_char = 1'b0;
        put_we_attr = 1'b0;
        put_addr    = lin;
        put_wchar   = '0;
        case (r_char)
            KEY_BS: begin
                if (r_col != '0) begin
                    col_t       = COLT_W'(r_col) - COLT_W'(1);
                    put_addr    = lin - ADDR_W'(1);
                    put_we_char = 1'b1;
                end
            end
            KEY_TAB: begin
                col_t = TAB_TBL[r_col];
            end
            KEY_CR: begin
                col_t = '0;
            end
            KEY_LF: begin
                col_t = '0;
                row_t = r_row + ROW_W'(1);
            end
            default: begin
                put_we_char = 1'b1;
                put_we_attr = 1'b1;
                put_wchar   = r_char;
                col_t       = COLT_W'(r_col) + COLT_W'(1);
            end
        endcase
        // wrap past the last column
        if (col_t >= COLT_W'(COLUMNS)) begin
            col_t = '0;
            row_t = r_row + ROW_W'(1);
        end
        put_scroll = (row_t == ROW_W'(ROWS - 1));
        put_row    = put_scroll ? ROW_W'(ROWS - 2) : row_t;
    end

    // Cursor and scroll flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.home) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.put_exec) begin
            r_col <= COL_W'(col_t);
            r_row <= put_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_scr <= 1'b0;
        end else if (i_cmd.put_exec && put_scroll) begin
            r_scr <= 1'b1;
        end
    end

    // Sweep counter and delayed scroll write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wpend <= 1'b0;
        end else begin
            r_wpend <= i_cmd.scroll_step;
            if (i_cmd.sweep_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.scroll_step || i_cmd.clear_step) begin
                r_cnt <= r_cnt + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scroll_step) begin
            r_waddr <= r_cnt;
            r_wzero <= !cnt_in_shift;
        end
    end

    // Write port select
    always_comb begin
        w_en_c = 1'b0;
        w_en_a = 1'b0;
        w_addr = r_cnt;
        w_char = '0;
        w_attr = '0;
        if (r_wpend) begin
            w_en_c = 1'b1;
            w_en_a = 1'b1;
            w_addr = r_waddr;
            w_char = r_wzero ? '0 : r_rd_char;
            w_attr = r_wzero ? '0 : r_rd_attr;
        end else if (i_cmd.clear_step) begin
            w_en_c = 1'b1;
            w_en_a = 1'b1;
        end else if (i_cmd.put_exec) begin
            w_en_c = put_we_char;
            w_en_a = put_we_attr;
            w_addr = put_addr;
            w_char = put_wchar;
            w_attr = r_attr;
        end
    end

    // Read port select
    assign rd_en   = (i_cmd.scroll_step && cnt_in_shift) || (i_cmd.rd_cell && idx_ok);
    assign rd_addr = i_cmd.scroll_step ? (r_cnt + ADDR_W'(COLUMNS)) : ADDR_W'(r_idx);

    // Store access
    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            mem_char[w_addr] <= w_char;
        end
        if (w_en_a) begin
            mem_attr[w_addr] <= w_attr;
        end
        if (rd_en) begin
            r_rd_char <= mem_char[rd_addr];
            r_rd_attr <= mem_attr[rd_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pos  <= lin_w[POS_W-1:0];
            r_out_char <= ((r_op == OP_READ) && idx_ok) ? r_rd_char : '0;
            r_out_attr <= ((r_op == OP_READ) && idx_ok) ? r_rd_attr : '0;
            r_out_scr  <= r_scr;
        end
    end

    assign o_cursor_pos = r_out_pos;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;
    assign o_scrolled   = r_out_scr;

    assign o_sts.op         = r_op;
    assign o_sts.put_scroll = put_scroll;
    assign o_sts.sweep_last = (r_cnt == ADDR_W'(USED_CELLS - 1));

    `TMCW_ASSERT_IMPLY(a_cursor_in_range, i_clk, i_rst_n, 1'b1,
        (int'(r_row) < ROWS - 1) && (int'(r_col) < COLUMNS), "cursor left the used area")
    `TMCW_ASSERT_IMPLY(a_wpend_after_step, i_clk, i_rst_n, r_wpend,
        $past(i_cmd.scroll_step), "scroll write without a scroll step")
    `TMCW_ASSERT_IMPLY(a_sweep_in_range, i_clk, i_rst_n, 1'b1,
        r_cnt <= ADDR_W'(USED_CELLS), "sweep counter ran past the store")

endmodule

// ===== rtl/text_mode_console_writer_top.sv =====
// Channel   Handshake                  Payload
// in        i_in_valid / o_in_ready    i_opcode, i_char_code, i_cell_index
// out       o_out_valid / i_out_ready  o_cursor_pos, o_cell_char, o_cell_attr, o_scrolled
// cfg       i_cfg_valid / o_cfg_ready  i_cfg_data (text attribute)
//
// Put, read and unused opcodes: the item passes through the execute and done states;
// the input is ready again in the cycle the result becomes valid, one item at a time.
// A put that scrolls, and clear-screen, add a one-cell-per-cycle sweep over every
// stored cell (COLUMNS*(ROWS-1), 1920 at 80x25) of the store.
// After reset the store is zeroed in the same sweep; no item is accepted
// until that sweep ends, configuration writes are taken throughout.
// A stalled result waits in the output register; the next item is accepted meanwhile.
module text_mode_console_writer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [tmcw_pkg::OP_W-1:0]   i_opcode,
    input  logic [tmcw_pkg::CHAR_W-1:0] i_char_code,
    input  logic [tmcw_pkg::IDX_W-1:0]  i_cell_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tmcw_pkg::POS_W-1:0]  o_cursor_pos,
    output logic [tmcw_pkg::CHAR_W-1:0] o_cell_char,
    output logic [tmcw_pkg::ATTR_W-1:0] o_cell_attr,
    output logic                        o_scrolled,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tmcw_pkg::ATTR_W-1:0] i_cfg_data
);
    import tmcw_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Attribute register takes a write in any cycle outside reset
    assign o_cfg_ready = 1'b1;

    tmcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tmcw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_opcode     (i_opcode),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .o_cursor_pos (o_cursor_pos),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr),
        .o_scrolled   (o_scrolled)
    );

endmodule
